@@ design/dtl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtl_pkg: shared definitions for the token lexer
// Position width, token kinds, scanner modes and character codes.
// ----------------------------------------------------------------------------
package dtl_pkg;

  localparam int POSITION_BITS = 16;
  localparam int LEN_BITS      = 16;
  localparam int KIND_BITS     = 5;
  localparam int MAX_TOKENS    = 3;

  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  typedef enum logic [KIND_BITS-1:0] {
    K_IDENT  = 5'd0,
    K_STRING = 5'd1,
    K_NUMBER = 5'd2,
    K_EQUALS = 5'd3,
    K_COLON  = 5'd4,
    K_ARROW  = 5'd5,
    K_LBRACE = 5'd6,
    K_RBRACE = 5'd7,
    K_LPAREN = 5'd8,
    K_RPAREN = 5'd9,
    K_EQEQ   = 5'd10,
    K_NE     = 5'd11,
    K_GT     = 5'd12,
    K_LT     = 5'd13,
    K_GE     = 5'd14,
    K_LE     = 5'd15,
    K_END    = 5'd16,
    K_ERROR  = 5'd17
  } token_kind_t;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_IDENT   = 4'd1,
    M_NUMBER  = 4'd2,
    M_MINUS   = 4'd3,
    M_STRING  = 4'd4,
    M_EQ      = 4'd5,
    M_BANG    = 4'd6,
    M_GT      = 4'd7,
    M_LT      = 4'd8,
    M_SLASH   = 4'd9,
    M_COMMENT = 4'd10
  } scan_mode_t;

  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  typedef struct packed {
    logic [KIND_BITS-1:0]     kind;
    logic [POSITION_BITS-1:0] start;
    logic [LEN_BITS-1:0]      len;
  } token_t;

  typedef struct packed {
    logic   valid;
    token_t tok;
  } flush_t;

endpackage
`default_nettype wire

@@ design/dsl_token_lexer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dsl_token_lexer: streaming lexical scanner
// Output: a token of an accepted beat is shown on the master side in the cycle
// after the accepting edge; a beat that yields several tokens shows them in order.
// Throughput: one input beat per cycle while beats yield at most one token and
// the master side is ready; a beat of more tokens holds off the next until they leave.
// Reset (rst, synchronous): scanner idle, offsets zero, no tokens pending.
// ----------------------------------------------------------------------------
module dsl_token_lexer (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave side: one source byte per beat
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
  input  wire logic [0:0]  s_tuser,   // [0] byte_present
  input  wire logic        s_tlast,   // end_of_source
  // master side: one token per beat
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [15:0] start_offset, [31:16] token_length
  output logic [4:0]       m_tuser,   // [4:0] token_kind
  output logic             m_tlast    // last_of_run
);
  import dtl_pkg::*;

  localparam int WIDE_BITS = POSITION_BITS + LEN_BITS;

  // Character classes, as the scanner needs them.
  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [LEN_BITS-1:0] grow(logic [LEN_BITS-1:0] n);
    return (n == LEN_MAX) ? n : n + 1'b1;
  endfunction

  function automatic logic [POSITION_BITS-1:0] sat_inc(logic [POSITION_BITS-1:0] p);
    return (p == {POSITION_BITS{1'b1}}) ? p : p + 1'b1;
  endfunction

  // Offsets leave the block as 16 bits and stop at their maximum.
  function automatic logic [LEN_BITS-1:0] sat_out(logic [POSITION_BITS-1:0] v);
    logic [WIDE_BITS-1:0] w;
    w = {{LEN_BITS{1'b0}}, v};
    if (w > WIDE_BITS'(LEN_MAX)) return LEN_MAX;
    return w[LEN_BITS-1:0];
  endfunction

  // The token left pending by a mode when it is cut off.
  function automatic flush_t flush_token(scan_mode_t m, logic [POSITION_BITS-1:0] s,
                                         logic [LEN_BITS-1:0] n);
    flush_t f;
    f.valid     = 1'b1;
    f.tok.start = s;
    f.tok.len   = LEN_BITS'(1);
    f.tok.kind  = K_ERROR;
    unique case (m)
      M_IDENT: begin
        f.tok.kind = K_IDENT;
        f.tok.len  = n;
      end
      M_NUMBER, M_MINUS: begin
        f.tok.kind = K_NUMBER;
        f.tok.len  = n;
      end
      M_STRING: begin
        f.tok.kind = K_STRING;
        f.tok.len  = n;
      end
      M_EQ:    f.tok.kind = K_EQUALS;
      M_BANG:  f.tok.kind = K_ERROR;
      M_GT:    f.tok.kind = K_GT;
      M_LT:    f.tok.kind = K_LT;
      M_SLASH: f.tok.kind = K_ERROR;
      default: f.valid = 1'b0;
    endcase
    return f;
  endfunction

  // Scanner state.
  scan_mode_t               mode;
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] tok_start;
  logic [LEN_BITS-1:0]      tok_count;

  scan_mode_t               mode_next;
  logic [POSITION_BITS-1:0] pos_next;
  logic [POSITION_BITS-1:0] tok_start_next;
  logic [LEN_BITS-1:0]      tok_count_next;

  // Result buffer: slot 0 is on the master port, later slots queue behind it.
  logic [KIND_BITS-1:0] out_kind  [MAX_TOKENS];
  logic [LEN_BITS-1:0]  out_start [MAX_TOKENS];
  logic [LEN_BITS-1:0]  out_len   [MAX_TOKENS];
  logic                 out_last  [MAX_TOKENS];
  logic [1:0]           cnt;

  // Candidate tokens of one beat, in emission order: the token cut off or
  // completed by this byte, a single-character token started and finished by
  // it, the token flushed at end of source, and the end token.
  logic   [3:0] cand_v;
  token_t       cand [4];
  token_t       slot [MAX_TOKENS];
  logic [1:0]   n_tok;

  logic [7:0] c;
  logic       present;
  logic       fall;
  logic       do_idle;
  flush_t     fl_byte;
  flush_t     fl_end;
  logic       accept;
  logic       beat;

  // Scanner state left by the byte alone, before end-of-source handling.
  logic [3:0]               scan_byte_mode;
  logic [POSITION_BITS-1:0] scan_byte_start;
  logic [LEN_BITS-1:0]      scan_byte_count;
  scan_mode_t               mode_scan;
  logic [POSITION_BITS-1:0] start_scan;
  logic [LEN_BITS-1:0]      count_scan;

  assign c       = s_tdata;
  assign present = s_tuser[0];
  assign accept  = s_tvalid && s_tready;
  assign beat    = m_tvalid && m_tready;

  // A new beat is taken when the buffer is empty, or its only token leaves now.
  assign s_tready = (cnt == 2'd0) || (cnt == 2'd1 && m_tready);
  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = {out_len[0], out_start[0]};
  assign m_tuser  = out_kind[0];
  assign m_tlast  = out_last[0];

  assign fl_byte = flush_token(mode, tok_start, tok_count);

  dtl_scan u_scan (
    .mode      (mode),
    .tok_start (tok_start),
    .tok_count (tok_count),
    .pos       (pos),
    .c         (c),
    .mode_o    (scan_byte_mode),
    .start_o   (scan_byte_start),
    .count_o   (scan_byte_count)
  );

  // With no byte in the beat the end flush sees the stored state.
  always_comb begin
    mode_scan  = mode;
    start_scan = tok_start;
    count_scan = tok_count;
    if (present) begin
      mode_scan  = scan_mode_t'(scan_byte_mode);
      start_scan = scan_byte_start;
      count_scan = scan_byte_count;
    end
  end

  // The end flush looks at the state left by the byte scan.
  assign fl_end = flush_token(mode_scan, start_scan, count_scan);

  always_comb begin
    mode_next      = mode;
    pos_next       = pos;
    tok_start_next = tok_start;
    tok_count_next = tok_count;
    fall           = 1'b0;
    do_idle        = 1'b0;
    cand_v         = '0;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end

    if (present) begin
      unique case (mode)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == CH_UNDER) tok_count_next = grow(tok_count);
          else fall = 1'b1;
        end
        M_NUMBER: begin
          if (is_digit(c) || c == CH_DOT) tok_count_next = grow(tok_count);
          else fall = 1'b1;
        end
        M_MINUS: begin
          // A minus directly followed by '>' is an arrow, not a number.
          if (c == CH_GT) begin
            cand_v[0]     = 1'b1;
            cand[0].kind  = K_ARROW;
            cand[0].start = tok_start;
            cand[0].len   = LEN_BITS'(2);
            mode_next     = M_IDLE;
          end else if (is_digit(c) || c == CH_DOT) begin
            mode_next      = M_NUMBER;
            tok_count_next = grow(tok_count);
          end else begin
            fall = 1'b1;
          end
        end
        M_STRING: begin
          if (c == CH_QUOTE) begin
            cand_v[0]     = 1'b1;
            cand[0].kind  = K_STRING;
            cand[0].start = tok_start;
            cand[0].len   = tok_count;
            mode_next     = M_IDLE;
          end else begin
            tok_count_next = grow(tok_count);
          end
        end
        M_EQ, M_BANG, M_GT, M_LT: begin
          if (c == CH_EQ) begin
            cand_v[0]     = 1'b1;
            cand[0].start = tok_start;
            cand[0].len   = LEN_BITS'(2);
            mode_next     = M_IDLE;
            unique case (mode)
              M_EQ:    cand[0].kind = K_EQEQ;
              M_BANG:  cand[0].kind = K_NE;
              M_GT:    cand[0].kind = K_GE;
              default: cand[0].kind = K_LE;
            endcase
          end else begin
            fall = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == CH_SLASH) mode_next = M_COMMENT;
          else fall = 1'b1;
        end
        M_COMMENT: begin
          if (c == CH_NEWLINE) mode_next = M_IDLE;
        end
        default: do_idle = 1'b1;
      endcase

      // The byte cannot extend the pending token: report it, then scan the
      // byte as if between tokens.
      if (fall) begin
        cand_v[0] = fl_byte.valid;
        cand[0]   = fl_byte.tok;
        mode_next = M_IDLE;
        do_idle   = 1'b1;
      end

      if (do_idle && !is_space(c)) begin
        priority if (is_alpha(c) || c == CH_UNDER) begin
          mode_next      = M_IDENT;
          tok_start_next = pos;
          tok_count_next = LEN_BITS'(1);
        end else if (is_digit(c) || c == CH_DOT) begin
          mode_next      = M_NUMBER;
          tok_start_next = pos;
          tok_count_next = LEN_BITS'(1);
        end else begin
          tok_start_next = pos;
          tok_count_next = LEN_BITS'(1);
          cand[1].start  = pos;
          cand[1].len    = LEN_BITS'(1);
          cand[1].kind   = K_ERROR;
          unique case (c)
            CH_MINUS: mode_next = M_MINUS;
            CH_QUOTE: begin
              // String text starts after the opening quote.
              mode_next      = M_STRING;
              tok_start_next = sat_inc(pos);
              tok_count_next = '0;
            end
            CH_EQ:     mode_next = M_EQ;
            CH_BANG:   mode_next = M_BANG;
            CH_GT:     mode_next = M_GT;
            CH_LT:     mode_next = M_LT;
            CH_SLASH:  mode_next = M_SLASH;
            CH_COLON: begin
              cand_v[1]      = 1'b1;
              cand[1].kind   = K_COLON;
              tok_start_next = tok_start;
              tok_count_next = tok_count;
            end
            CH_LBRACE: begin
              cand_v[1]      = 1'b1;
              cand[1].kind   = K_LBRACE;
              tok_start_next = tok_start;
              tok_count_next = tok_count;
            end
            CH_RBRACE: begin
              cand_v[1]      = 1'b1;
              cand[1].kind   = K_RBRACE;
              tok_start_next = tok_start;
              tok_count_next = tok_count;
            end
            CH_LPAREN: begin
              cand_v[1]      = 1'b1;
              cand[1].kind   = K_LPAREN;
              tok_start_next = tok_start;
              tok_count_next = tok_count;
            end
            CH_RPAREN: begin
              cand_v[1]      = 1'b1;
              cand[1].kind   = K_RPAREN;
              tok_start_next = tok_start;
              tok_count_next = tok_count;
            end
            default: begin
              cand_v[1]      = 1'b1;
              tok_start_next = tok_start;
              tok_count_next = tok_count;
            end
          endcase
        end
      end

      pos_next = sat_inc(pos);
    end

    // End of source: flush what is pending, report the end token at the
    // position after the last byte, then start over from offset zero.
    if (s_tlast) begin
      cand_v[2]      = fl_end.valid;
      cand[2]        = fl_end.tok;
      cand_v[3]      = 1'b1;
      cand[3].kind   = K_END;
      cand[3].start  = pos_next;
      cand[3].len    = '0;
      mode_next      = M_IDLE;
      pos_next       = '0;
      tok_start_next = '0;
      tok_count_next = '0;
    end
  end

  // Pack the candidates into the buffer slots in order.
  always_comb begin
    n_tok = '0;
    for (int i = 0; i < MAX_TOKENS; i++) begin
      slot[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && n_tok < 2'd3) begin
        slot[n_tok] = cand[i];
        n_tok       = n_tok + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      mode      <= M_IDLE;
      pos       <= '0;
      tok_start <= '0;
      tok_count <= '0;
    end else begin
      if (accept) begin
        mode      <= mode_next;
        pos       <= pos_next;
        tok_start <= tok_start_next;
        tok_count <= tok_count_next;
        cnt       <= n_tok;
        for (int i = 0; i < MAX_TOKENS; i++) begin
          out_kind[i]  <= slot[i].kind;
          out_start[i] <= sat_out(slot[i].start);
          out_len[i]   <= slot[i].len;
          out_last[i]  <= (2'(i) == n_tok - 2'd1);
        end
      end else if (beat) begin
        cnt <= cnt - 2'd1;
        for (int i = 0; i < MAX_TOKENS - 1; i++) begin
          out_kind[i]  <= out_kind[i+1];
          out_start[i] <= out_start[i+1];
          out_len[i]   <= out_len[i+1];
          out_last[i]  <= out_last[i+1];
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ design/dtl_scan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtl_scan: scanner state after one byte
// Mode, token start and length that one source byte leaves behind.
// ----------------------------------------------------------------------------
module dtl_scan (
  input  wire logic [3:0]                       mode,
  input  wire logic [dtl_pkg::POSITION_BITS-1:0] tok_start,
  input  wire logic [dtl_pkg::LEN_BITS-1:0]      tok_count,
  input  wire logic [dtl_pkg::POSITION_BITS-1:0] pos,
  input  wire logic [7:0]                       c,
  output logic [3:0]                            mode_o,
  output logic [dtl_pkg::POSITION_BITS-1:0]     start_o,
  output logic [dtl_pkg::LEN_BITS-1:0]          count_o
);
  import dtl_pkg::*;

  logic alpha;
  logic digit;
  logic space;
  logic idle_scan;

  assign alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  assign digit = (c >= 8'h30 && c <= 8'h39);
  assign space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);

  always_comb begin
    mode_o    = mode;
    start_o   = tok_start;
    count_o   = tok_count;
    idle_scan = 1'b0;
    unique case (mode)
      M_IDENT: begin
        if (alpha || digit || c == CH_UNDER) begin
          count_o = (tok_count == LEN_MAX) ? tok_count : tok_count + 1'b1;
        end else begin
          idle_scan = 1'b1;
        end
      end
      M_NUMBER: begin
        if (digit || c == CH_DOT) begin
          count_o = (tok_count == LEN_MAX) ? tok_count : tok_count + 1'b1;
        end else begin
          idle_scan = 1'b1;
        end
      end
      M_MINUS: begin
        if (c == CH_GT) begin
          mode_o = M_IDLE;
        end else if (digit || c == CH_DOT) begin
          mode_o  = M_NUMBER;
          count_o = (tok_count == LEN_MAX) ? tok_count : tok_count + 1'b1;
        end else begin
          idle_scan = 1'b1;
        end
      end
      M_STRING: begin
        if (c == CH_QUOTE) mode_o = M_IDLE;
        else count_o = (tok_count == LEN_MAX) ? tok_count : tok_count + 1'b1;
      end
      M_EQ, M_BANG, M_GT, M_LT: begin
        if (c == CH_EQ) mode_o = M_IDLE;
        else idle_scan = 1'b1;
      end
      M_SLASH: begin
        if (c == CH_SLASH) mode_o = M_COMMENT;
        else idle_scan = 1'b1;
      end
      M_COMMENT: begin
        if (c == CH_NEWLINE) mode_o = M_IDLE;
      end
      default: idle_scan = 1'b1;
    endcase

    if (idle_scan) begin
      mode_o = M_IDLE;
      if (!space) begin
        priority if (alpha || c == CH_UNDER) begin
          mode_o  = M_IDENT;
          start_o = pos;
          count_o = LEN_BITS'(1);
        end else if (digit || c == CH_DOT) begin
          mode_o  = M_NUMBER;
          start_o = pos;
          count_o = LEN_BITS'(1);
        end else if (c == CH_QUOTE) begin
          mode_o  = M_STRING;
          start_o = (pos == {POSITION_BITS{1'b1}}) ? pos : pos + 1'b1;
          count_o = '0;
        end else if (c == CH_MINUS || c == CH_EQ || c == CH_BANG || c == CH_GT ||
                     c == CH_LT || c == CH_SLASH) begin
          start_o = pos;
          count_o = LEN_BITS'(1);
          unique case (c)
            CH_MINUS: mode_o = M_MINUS;
            CH_EQ:    mode_o = M_EQ;
            CH_BANG:  mode_o = M_BANG;
            CH_GT:    mode_o = M_GT;
            CH_LT:    mode_o = M_LT;
            default:  mode_o = M_SLASH;
          endcase
        end else begin
          // Tokens finished by this one byte leave the pending fields alone.
          mode_o = M_IDLE;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ design/dtl_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtl_checker: port-level checks for the token lexer
// Watches both stream ports and flags bad token beats and input stalls.
// ----------------------------------------------------------------------------
module dtl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [4:0]  m_tuser,
  input wire logic        m_tlast
);
  import dtl_pkg::*;

  // A stalled token beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("token beat changed while stalled");

  // The end token closes the run of its beat and has no text.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == K_END |-> m_tlast && m_tdata[31:16] == 16'd0)
    else $error("end token not last or not empty");

  // With nothing waiting on the master side the lexer takes a byte.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("lexer stalled with an empty output");

  // An end-of-source beat that is taken yields a valid token beat next cycle.
  a_end_follows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid)
    else $error("no token after end of source");

  // Kinds stay within the defined codes.
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= K_ERROR)
    else $error("undefined token kind");

endmodule

bind dsl_token_lexer dtl_checker u_dtl_checker (.*);
`default_nettype wire
